// ----- hdl/prt_pkg.sv -----
package prt_pkg;

    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 16;
    localparam int TRIG_STAGES = 16;
    localparam int TRIG_Q      = 30;
    localparam int COEF_FRAC   = ((61 - COORD_W) < TRIG_Q) ? (61 - COORD_W) : TRIG_Q;
    localparam int TURN_W      = 32;
    localparam int CORDIC_W    = TRIG_Q + 4;
    localparam int Z_W         = TURN_W + 2;
    localparam int COEF_W      = COEF_FRAC + 3;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = DIFF_W + COEF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int RES_W       = SUM_W - COEF_FRAC + 1;
    localparam int ATAN_N      = 24;
    localparam int IN_TDATA_W  = ((6 * COORD_W + ANGLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    localparam logic [1:0] OP_XY   = 2'd0;
    localparam logic [1:0] OP_YZ   = 2'd1;
    localparam logic [1:0] OP_ZX   = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic                      flip;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
    } t_cordic;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] ca;
        logic signed [COORD_W-1:0] cb;
        logic signed [DIFF_W-1:0]  da;
        logic signed [DIFF_W-1:0]  db;
    } t_side;

    function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return {{(Z_W-32){1'b0}}, v};
    endfunction

endpackage

// ----- hdl/prt_prep.sv -----
module prt_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic signed [prt_pkg::COORD_W-1:0] i_px,
    input  logic signed [prt_pkg::COORD_W-1:0] i_py,
    input  logic signed [prt_pkg::COORD_W-1:0] i_pz,
    input  logic signed [prt_pkg::COORD_W-1:0] i_cx,
    input  logic signed [prt_pkg::COORD_W-1:0] i_cy,
    input  logic signed [prt_pkg::COORD_W-1:0] i_cz,
    input  logic [prt_pkg::ANGLE_W-1:0]        i_angle,
    output logic                              o_valid,
    input  logic                              i_ready,
    output prt_pkg::t_cordic                  o_st,
    output prt_pkg::t_side                    o_side
);
    import prt_pkg::*;

    logic                      r_valid;
    t_cordic                   r_st;
    t_side                     r_side;
    t_cordic                   n_st;
    t_side                     n_side;
    logic [TURN_W-1:0]         turn;
    logic [TURN_W-1:0]         folded;
    logic signed [COORD_W-1:0] pa;
    logic signed [COORD_W-1:0] pb;
    logic signed [COORD_W-1:0] ca;
    logic signed [COORD_W-1:0] cb;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        turn   = {i_angle, {(TURN_W-ANGLE_W){1'b0}}};
        n_st.flip = (turn[TURN_W-1:TURN_W-2] == 2'd1) || (turn[TURN_W-1:TURN_W-2] == 2'd2);
        folded = {turn[TURN_W-1] ^ n_st.flip, turn[TURN_W-2:0]};
        n_st.x = CORDIC_GAIN;
        n_st.y = '0;
        n_st.z = {{(Z_W-TURN_W){folded[TURN_W-1]}}, folded};

        case (i_op)
            OP_XY: begin
                pa = i_px; pb = i_py; ca = i_cx; cb = i_cy;
            end
            OP_YZ: begin
                pa = i_py; pb = i_pz; ca = i_cy; cb = i_cz;
            end
            OP_ZX: begin
                pa = i_px; pb = i_pz; ca = i_cx; cb = i_cz;
            end
            default: begin
                pa = '0; pb = '0; ca = '0; cb = '0;
            end
        endcase

        n_side.op = i_op;
        n_side.px = i_px;
        n_side.py = i_py;
        n_side.pz = i_pz;
        n_side.ca = ca;
        n_side.cb = cb;
        n_side.da = DIFF_W'(pa) - DIFF_W'(ca);
        n_side.db = DIFF_W'(pb) - DIFF_W'(cb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_st   <= n_st;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;
    assign o_side  = r_side;

endmodule

// ----- hdl/prt_cordic.sv -----
module prt_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  prt_pkg::t_cordic i_st,
    input  prt_pkg::t_side   i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output prt_pkg::t_cordic o_st,
    output prt_pkg::t_side   o_side
);
    import prt_pkg::*;

    logic    w_valid [0:TRIG_STAGES];
    logic    w_rdy   [0:TRIG_STAGES];
    t_cordic w_st    [0:TRIG_STAGES];
    t_side   w_side  [0:TRIG_STAGES];

    assign w_valid[0]           = i_valid;
    assign w_st[0]              = i_st;
    assign w_side[0]            = i_side;
    assign w_rdy[TRIG_STAGES]   = i_ready;
    assign o_ready              = w_rdy[0];

    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_stage
        logic                       r_valid;
        t_cordic                    r_st;
        t_side                      r_side;
        t_cordic                    n_st;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;

        assign w_rdy[k] = !r_valid || w_rdy[k+1];

        always_comb begin
            xs = w_st[k].x >>> k;
            ys = w_st[k].y >>> k;
            n_st.flip = w_st[k].flip;
            if (!w_st[k].z[Z_W-1]) begin
                n_st.x = w_st[k].x - ys;
                n_st.y = w_st[k].y + xs;
                n_st.z = w_st[k].z - atan_turn(k);
            end else begin
                n_st.x = w_st[k].x + ys;
                n_st.y = w_st[k].y - xs;
                n_st.z = w_st[k].z + atan_turn(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (w_rdy[k]) begin
                r_valid <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_st   <= n_st;
                r_side <= w_side[k];
            end
        end

        assign w_valid[k+1] = r_valid;
        assign w_st[k+1]    = r_st;
        assign w_side[k+1]  = r_side;
    end

    assign o_valid = w_valid[TRIG_STAGES];
    assign o_st    = w_st[TRIG_STAGES];
    assign o_side  = w_side[TRIG_STAGES];

endmodule

// ----- hdl/prt_rotate.sv -----
module prt_rotate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  prt_pkg::t_cordic                  i_st,
    input  prt_pkg::t_side                    i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [prt_pkg::COORD_W-1:0] o_x,
    output logic signed [prt_pkg::COORD_W-1:0] o_y,
    output logic signed [prt_pkg::COORD_W-1:0] o_z,
    output logic                              o_sat
);
    import prt_pkg::*;

    localparam logic signed [CORDIC_W-1:0] RND_TRIG =
        (TRIG_Q > COEF_FRAC) ? (CORDIC_W'(1) << (TRIG_Q - COEF_FRAC - 1)) : CORDIC_W'(0);
    localparam logic signed [SUM_W-1:0]    RND_HALF = SUM_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [RES_W-1:0]    SAT_HI   = (RES_W'(1) << (COORD_W - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0]    SAT_LO   = -SAT_HI - RES_W'(1);

    logic                       rdy_a;
    logic                       rdy_b;
    logic                       rdy_c;
    logic                       rdy_d;

    logic                       r_a_valid;
    logic signed [COEF_W-1:0]   r_a_cos;
    logic signed [COEF_W-1:0]   r_a_sin;
    t_side                      r_a_side;

    logic                       r_b_valid;
    logic signed [PROD_W-1:0]   r_b_ac;
    logic signed [PROD_W-1:0]   r_b_bs;
    logic signed [PROD_W-1:0]   r_b_bc;
    logic signed [PROD_W-1:0]   r_b_as;
    t_side                      r_b_side;

    logic                       r_c_valid;
    logic signed [SUM_W-1:0]    r_c_sa;
    logic signed [SUM_W-1:0]    r_c_sb;
    t_side                      r_c_side;

    logic                       r_d_valid;
    logic signed [COORD_W-1:0]  r_d_x;
    logic signed [COORD_W-1:0]  r_d_y;
    logic signed [COORD_W-1:0]  r_d_z;
    logic                       r_d_sat;

    logic signed [CORDIC_W-1:0] cos_full;
    logic signed [CORDIC_W-1:0] sin_full;
    logic signed [CORDIC_W-1:0] cos_rnd;
    logic signed [CORDIC_W-1:0] sin_rnd;
    logic signed [COEF_W-1:0]   n_a_cos;
    logic signed [COEF_W-1:0]   n_a_sin;

    logic signed [SUM_W-1:0]    n_c_sa;
    logic signed [SUM_W-1:0]    n_c_sb;

    logic signed [RES_W-1:0]    ra;
    logic signed [RES_W-1:0]    rb;
    logic signed [COORD_W-1:0]  qa;
    logic signed [COORD_W-1:0]  qb;
    logic                       sat_a;
    logic                       sat_b;
    logic signed [COORD_W-1:0]  n_d_x;
    logic signed [COORD_W-1:0]  n_d_y;
    logic signed [COORD_W-1:0]  n_d_z;
    logic                       n_d_sat;

    assign rdy_d   = !r_d_valid || i_ready;
    assign rdy_c   = !r_c_valid || rdy_d;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        cos_full = i_st.flip ? -i_st.x : i_st.x;
        sin_full = i_st.flip ? -i_st.y : i_st.y;
        cos_rnd  = cos_full + RND_TRIG;
        sin_rnd  = sin_full + RND_TRIG;
        n_a_cos  = COEF_W'(cos_rnd >>> (TRIG_Q - COEF_FRAC));
        n_a_sin  = COEF_W'(sin_rnd >>> (TRIG_Q - COEF_FRAC));
    end

    always_comb begin
        n_c_sa = SUM_W'(r_b_ac) + SUM_W'(r_b_bs) + RND_HALF;
        n_c_sb = SUM_W'(r_b_bc) - SUM_W'(r_b_as) + RND_HALF;
    end

    always_comb begin
        ra = RES_W'(r_c_side.ca) + RES_W'(r_c_sa >>> COEF_FRAC);
        rb = RES_W'(r_c_side.cb) + RES_W'(r_c_sb >>> COEF_FRAC);

        sat_a = 1'b0;
        if (ra > SAT_HI) begin
            qa    = COORD_W'(SAT_HI);
            sat_a = 1'b1;
        end else if (ra < SAT_LO) begin
            qa    = COORD_W'(SAT_LO);
            sat_a = 1'b1;
        end else begin
            qa = COORD_W'(ra);
        end

        sat_b = 1'b0;
        if (rb > SAT_HI) begin
            qb    = COORD_W'(SAT_HI);
            sat_b = 1'b1;
        end else if (rb < SAT_LO) begin
            qb    = COORD_W'(SAT_LO);
            sat_b = 1'b1;
        end else begin
            qb = COORD_W'(rb);
        end

        n_d_x   = r_c_side.px;
        n_d_y   = r_c_side.py;
        n_d_z   = r_c_side.pz;
        n_d_sat = sat_a || sat_b;
        case (r_c_side.op)
            OP_XY: begin
                n_d_x = qa;
                n_d_y = qb;
            end
            OP_YZ: begin
                n_d_y = qa;
                n_d_z = qb;
            end
            OP_ZX: begin
                n_d_x = qa;
                n_d_z = qb;
            end
            default: begin
                n_d_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_cos  <= n_a_cos;
            r_a_sin  <= n_a_sin;
            r_a_side <= i_side;
        end
        if (rdy_b) begin
            r_b_ac   <= PROD_W'(r_a_side.da) * PROD_W'(r_a_cos);
            r_b_bs   <= PROD_W'(r_a_side.db) * PROD_W'(r_a_sin);
            r_b_bc   <= PROD_W'(r_a_side.db) * PROD_W'(r_a_cos);
            r_b_as   <= PROD_W'(r_a_side.da) * PROD_W'(r_a_sin);
            r_b_side <= r_a_side;
        end
        if (rdy_c) begin
            r_c_sa   <= n_c_sa;
            r_c_sb   <= n_c_sb;
            r_c_side <= r_b_side;
        end
        if (rdy_d) begin
            r_d_x   <= n_d_x;
            r_d_y   <= n_d_y;
            r_d_z   <= n_d_z;
            r_d_sat <= n_d_sat;
        end
    end

    assign o_valid = r_d_valid;
    assign o_x     = r_d_x;
    assign o_y     = r_d_y;
    assign o_z     = r_d_z;
    assign o_sat   = r_d_sat;

endmodule

// ----- hdl/point_rotate_about_center_core.sv -----
// Pipeline: an accepted request reaches its result on the master side through these registered stages
// (1 setup stage, 16 CORDIC iteration stages, coefficient, multiply, sum and output stages).
// Throughput: one request per cycle; each stage holds its item while the next one is full.
// Reset: i_rst_n synchronous, active low; clears every stage valid bit, data is not reset.
module point_rotate_about_center_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z, angle
    input  logic [prt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x, out_y, out_z
    output logic [prt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // saturated
    output logic [0:0]                         m_axis_tuser
);
    import prt_pkg::*;

    logic                      prep_valid;
    logic                      prep_ready;
    t_cordic                   prep_st;
    t_side                     prep_side;
    logic                      cord_valid;
    logic                      cord_ready;
    t_cordic                   cord_st;
    t_side                     cord_side;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_sat;

    prt_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_px    (s_axis_tdata[COORD_W-1:0]),
        .i_py    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_pz    (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .i_cx    (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
        .i_cy    (s_axis_tdata[5*COORD_W-1:4*COORD_W]),
        .i_cz    (s_axis_tdata[6*COORD_W-1:5*COORD_W]),
        .i_angle (s_axis_tdata[6*COORD_W+ANGLE_W-1:6*COORD_W]),
        .o_valid (prep_valid),
        .i_ready (prep_ready),
        .o_st    (prep_st),
        .o_side  (prep_side)
    );

    prt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_ready (prep_ready),
        .i_st    (prep_st),
        .i_side  (prep_side),
        .o_valid (cord_valid),
        .i_ready (cord_ready),
        .o_st    (cord_st),
        .o_side  (cord_side)
    );

    prt_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cord_valid),
        .o_ready (cord_ready),
        .i_st    (cord_st),
        .i_side  (cord_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_z     (out_z),
        .o_sat   (out_sat)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_z, out_y, out_x});
    assign m_axis_tuser = out_sat;

endmodule
